// File: rtl/apwa_pkg.sv
// ----------------------------------------------------------------------------
// apwa_pkg
// Shared types, codes and the header decode function for the ASK packet word assembler.
// ----------------------------------------------------------------------------
package apwa_pkg;

    localparam int WORD_W    = 11;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 8;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int HDR_W     = 9;

    localparam int MAX_WORDS = 16;

    localparam logic [COUNT_W-1:0] PREAMBLE_MIN_RST = 8'd11;
    localparam logic [COUNT_W-1:0] PREAMBLE_MAX_RST = 8'd25;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = 8'hFF;
    localparam logic [POS_W-1:0]   POS_TOP          = 4'd10;

    localparam logic [KIND_W-1:0] KIND_UNCOUNTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREAMBLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT     = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_GOOD       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PARITY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_MAX = 1'd1;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [INDEX_W-1:0]  word_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    function automatic logic [LEN_W-1:0] header_length(input logic [HDR_W-1:0] hdr);
        logic [LEN_W-1:0] len;
        unique case (hdr)
            9'h001, 9'h003, 9'h004: len = 4'd3;
            9'h051:                 len = 4'd7;
            9'h071:                 len = 4'd9;
            9'h0FF:                 len = 4'd2;
            default:                len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/apwa_rx.sv
// ----------------------------------------------------------------------------
// apwa_rx
// Preamble detection, bit assembly, parity and header decode; one bit per cycle while accept is high.
// ----------------------------------------------------------------------------
module apwa_rx (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [apwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apwa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           accept,
    input  logic [apwa_pkg::KIND_W-1:0]    kind,
    input  logic                           bit_value,
    output logic                           res_valid,
    output apwa_pkg::result_t              res
);
    import apwa_pkg::*;

    logic [COUNT_W-1:0] preamble_min_reg, preamble_min_next;
    logic [COUNT_W-1:0] preamble_max_reg, preamble_max_next;
    logic [COUNT_W-1:0] preamble_ones_reg, preamble_ones_next;
    logic [COUNT_W-1:0] other_bits_reg, other_bits_next;
    logic               recording_reg, recording_next;
    logic [POS_W-1:0]   bit_position_reg, bit_position_next;
    logic [WORD_W-1:0]  word_shift_reg, word_shift_next;
    logic [INDEX_W-1:0] word_count_reg, word_count_next;
    logic [LEN_W-1:0]   packet_length_reg, packet_length_next;

    logic               rec;
    logic               stop;
    logic [POS_W-1:0]   pos;
    logic [WORD_W-1:0]  ws;
    logic [INDEX_W:0]   idx_inc;
    logic [LEN_W-1:0]   plen;
    logic               last;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] pre_base;
    logic [COUNT_W-1:0] oth_base;

    always_comb begin
        preamble_min_next = preamble_min_reg;
        preamble_max_next = preamble_max_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_PREAMBLE_MIN: preamble_min_next = cfg_wdata;
                CFG_PREAMBLE_MAX: preamble_max_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        preamble_ones_next = preamble_ones_reg;
        other_bits_next    = other_bits_reg;
        recording_next     = recording_reg;
        bit_position_next  = bit_position_reg;
        word_shift_next    = word_shift_reg;
        word_count_next    = word_count_reg;
        packet_length_next = packet_length_reg;
        res_valid          = 1'b0;
        stop               = 1'b0;
        last               = 1'b0;
        status             = STATUS_GOOD;
        plen               = packet_length_reg;
        idx_inc            = {1'b0, word_count_reg} + 1'b1;
        pos                = (bit_position_reg > POS_TOP) ? POS_TOP : bit_position_reg;
        ws                 = word_shift_reg;
        ws[pos]            = bit_value;
        rec                = recording_reg
                           | ((preamble_ones_reg >= preamble_min_reg)
                              && (preamble_ones_reg <= preamble_max_reg)
                              && (other_bits_reg == '0) && !bit_value);
        pre_base           = preamble_ones_reg;
        oth_base           = other_bits_reg;

        if (accept) begin
            if (kind == KIND_ABORT) begin
                stop = 1'b1;
            end else if (rec) begin
                recording_next  = 1'b1;
                word_shift_next = ws;
                if (pos != '0) begin
                    bit_position_next = pos - 1'b1;
                end else begin
                    bit_position_next = POS_TOP;
                    word_count_next   = idx_inc[INDEX_W-1:0];
                    res_valid         = 1'b1;
                    if (!(^ws[9:1])) begin
                        status = STATUS_PARITY;
                        last   = 1'b1;
                    end else begin
                        if (word_count_reg == '0) begin
                            plen               = header_length(ws[WORD_W-1:2]);
                            packet_length_next = plen;
                            if (plen == '0) begin
                                status = STATUS_BAD_HEADER;
                                last   = 1'b1;
                            end
                        end
                        if ((idx_inc == {1'b0, plen})
                            || (idx_inc >= (INDEX_W+1)'(MAX_WORDS))) begin
                            last = 1'b1;
                        end
                    end
                    stop = last;
                end
            end

            if (stop) begin
                recording_next     = 1'b0;
                bit_position_next  = POS_TOP;
                word_count_next    = '0;
                packet_length_next = '0;
                pre_base           = '0;
                oth_base           = '0;
            end
            preamble_ones_next = pre_base;
            other_bits_next    = oth_base;
            if (kind == KIND_PREAMBLE && pre_base != COUNT_SAT) begin
                preamble_ones_next = pre_base + 1'b1;
            end
            if (kind == KIND_OTHER && oth_base != COUNT_SAT) begin
                other_bits_next = oth_base + 1'b1;
            end
        end

        res.word       = ws;
        res.word_index = word_count_reg;
        res.status     = status;
        res.last       = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_min_reg  <= PREAMBLE_MIN_RST;
            preamble_max_reg  <= PREAMBLE_MAX_RST;
            preamble_ones_reg <= '0;
            other_bits_reg    <= '0;
            recording_reg     <= 1'b0;
            bit_position_reg  <= POS_TOP;
            word_count_reg    <= '0;
            packet_length_reg <= '0;
        end else begin
            preamble_min_reg  <= preamble_min_next;
            preamble_max_reg  <= preamble_max_next;
            preamble_ones_reg <= preamble_ones_next;
            other_bits_reg    <= other_bits_next;
            recording_reg     <= recording_next;
            bit_position_reg  <= bit_position_next;
            word_count_reg    <= word_count_next;
            packet_length_reg <= packet_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_shift_reg <= word_shift_next;
    end

endmodule

// File: rtl/apwa_outbuf.sv
// ----------------------------------------------------------------------------
// apwa_outbuf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module apwa_outbuf (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  apwa_pkg::result_t               push_data,
    output logic                            space,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [apwa_pkg::WORD_W-1:0]     m_word,
    output logic [apwa_pkg::INDEX_W-1:0]    m_word_index,
    output logic [apwa_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_last
);
    import apwa_pkg::*;

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop   = head_valid_reg && m_ready;
    assign space = !skid_valid_reg;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        unique case ({push, pop})
            2'b10: begin
                if (!head_valid_reg) begin
                    head_next       = push_data;
                    head_valid_next = 1'b1;
                end else begin
                    skid_next       = push_data;
                    skid_valid_next = 1'b1;
                end
            end
            2'b01: begin
                if (skid_valid_reg) begin
                    head_next       = skid_reg;
                    skid_valid_next = 1'b0;
                end else begin
                    head_valid_next = 1'b0;
                end
            end
            2'b11: begin
                if (skid_valid_reg) begin
                    head_next = skid_reg;
                    skid_next = push_data;
                end else begin
                    head_next = push_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_valid      = head_valid_reg;
    assign m_word       = head_reg.word;
    assign m_word_index = head_reg.word_index;
    assign m_status     = head_reg.status;
    assign m_last       = head_reg.last;

endmodule

// File: rtl/ask_packet_word_assembler.sv
// ----------------------------------------------------------------------------
// ask_packet_word_assembler
// Assembles decoded ASK line bits into checked, indexed packet words.
// ----------------------------------------------------------------------------
// A finished word is pushed into the output buffer when the request holding its
// last bit is accepted, and is shown on m_valid once it sits in the head register.
// Throughput: one request per cycle while s_ready is high; the state update is a
// single register step, and the two-entry buffer drops s_ready only when full.
// Reset: aresetn (synchronous) idles the receiver and restores the preamble
// window to 11..25.
// ----------------------------------------------------------------------------
module ask_packet_word_assembler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [apwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apwa_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [apwa_pkg::KIND_W-1:0]     s_kind,
    input  logic                            s_bit_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [apwa_pkg::WORD_W-1:0]     m_word,
    output logic [apwa_pkg::INDEX_W-1:0]    m_word_index,
    output logic [apwa_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_last
);
    import apwa_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    apwa_rx u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .kind      (s_kind),
        .bit_value (s_bit_value),
        .res_valid (res_valid),
        .res       (res)
    );

    apwa_outbuf u_outbuf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (res_valid),
        .push_data    (res),
        .space        (space),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word       (m_word),
        .m_word_index (m_word_index),
        .m_status     (m_status),
        .m_last       (m_last)
    );

endmodule

// File: tb/sv/apwa_word_checker.sv
// ----------------------------------------------------------------------------
// apwa_word_checker
// Scoreboard for the ASK packet word assembler. It tracks the preamble window
// registers, rebuilds each packet word from the accepted bit requests, and
// checks every word that leaves the block, field by field and in order.
// ----------------------------------------------------------------------------
package apwa_tb_pkg;

    localparam logic [8:0] HDR_SIGNAL   = 9'h001;
    localparam logic [8:0] HDR_CTRL_ERR = 9'h003;
    localparam logic [8:0] HDR_RX_POWER = 9'h004;
    localparam logic [8:0] HDR_CONFIG   = 9'h051;
    localparam logic [8:0] HDR_IDENT    = 9'h071;
    localparam logic [8:0] HDR_FILL     = 9'h0FF;

    function automatic int words_in_packet(input logic [8:0] code);
        int n;
        case (code)
            HDR_SIGNAL, HDR_CTRL_ERR, HDR_RX_POWER: n = 3;
            HDR_CONFIG: n = 7;
            HDR_IDENT:  n = 9;
            HDR_FILL:   n = 2;
            default:    n = 0;
        endcase
        return n;
    endfunction

endpackage

module apwa_word_checker
    import apwa_pkg::*;
    import apwa_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic                 s_bit_value,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [WORD_W-1:0]    m_word,
    input  logic [INDEX_W-1:0]   m_word_index,
    input  logic [STATUS_W-1:0]  m_status,
    input  logic                 m_last,
    output int                   mismatches,
    output int                   pending,
    output int                   words_checked,
    output int                   parity_words,
    output int                   bad_headers
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [COUNT_W-1:0] win_min;
    logic [COUNT_W-1:0] win_max;
    logic [COUNT_W-1:0] pre_ones;
    logic [COUNT_W-1:0] other_cnt;
    logic               rec;
    logic [POS_W-1:0]   bit_pos;
    logic [WORD_W-1:0]  shift_reg;
    logic [INDEX_W-1:0] words_done;
    logic [LEN_W-1:0]   pkt_len;

    result_t pending_words[$];
    result_t exp_w;
    int      n_bad;
    int      n_words;
    int      n_parity;
    int      n_header;

    task automatic return_to_idle();
        pre_ones   = '0;
        other_cnt  = '0;
        rec        = 1'b0;
        bit_pos    = POS_TOP;
        words_done = '0;
        pkt_len    = '0;
    endtask

    task automatic assemble_bit(input logic [KIND_W-1:0] kind, input logic b);
        result_t          r;
        logic [POS_W-1:0] pos;
        if (kind == KIND_ABORT) begin
            return_to_idle();
        end else begin
            if (pre_ones >= win_min && pre_ones <= win_max && other_cnt == 0 && !b)
                rec = 1'b1;
            if (rec) begin
                pos = (bit_pos > POS_TOP) ? POS_TOP : bit_pos;
                shift_reg[pos] = b;
                if (pos != 0) begin
                    bit_pos = pos - 1'b1;
                end else begin
                    r.word       = shift_reg;
                    r.word_index = words_done;
                    r.status     = STATUS_GOOD;
                    r.last       = 1'b0;
                    bit_pos      = POS_TOP;
                    words_done   = words_done + 1'b1;
                    if (^shift_reg[9:1] == 1'b0) begin
                        r.status = STATUS_PARITY;
                        r.last   = 1'b1;
                    end else begin
                        if (r.word_index == 0) begin
                            pkt_len = LEN_W'(words_in_packet(shift_reg[10:2]));
                            if (pkt_len == 0) begin
                                r.status = STATUS_BAD_HEADER;
                                r.last   = 1'b1;
                            end
                        end
                        if (r.word_index + 1 == pkt_len || r.word_index + 1 >= MAX_WORDS)
                            r.last = 1'b1;
                    end
                    pending_words.push_back(r);
                    if (r.last)
                        return_to_idle();
                end
            end
            if (kind == KIND_PREAMBLE && pre_ones != COUNT_SAT)
                pre_ones = pre_ones + 1'b1;
            else if (kind == KIND_OTHER && other_cnt != COUNT_SAT)
                other_cnt = other_cnt + 1'b1;
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] expv,
                                 input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t ns: word %0d %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, n_words, field, expv, actv);
            n_bad++;
        end
    endtask

    initial begin
        n_bad    = 0;
        n_words  = 0;
        n_parity = 0;
        n_header = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_min   = PREAMBLE_MIN_RST;
            win_max   = PREAMBLE_MAX_RST;
            shift_reg = '0;
            return_to_idle();
            pending_words.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PREAMBLE_MIN: win_min = cfg_wdata;
                    CFG_PREAMBLE_MAX: win_max = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t ns: unexpected word 0x%0h index %0d status %0d last %0b",
                             $time, m_word, m_word_index, m_status, m_last);
                    n_bad++;
                end else begin
                    exp_w = pending_words.pop_front();
                    compare_field("word", exp_w.word, m_word);
                    compare_field("word_index", exp_w.word_index, m_word_index);
                    compare_field("status", exp_w.status, m_status);
                    compare_field("last", exp_w.last, m_last);
                    n_words++;
                    if (exp_w.status == STATUS_PARITY)
                        n_parity++;
                    if (exp_w.status == STATUS_BAD_HEADER)
                        n_header++;
                end
            end
            if (s_valid && s_ready)
                assemble_bit(s_kind, s_bit_value);
        end
        mismatches    <= n_bad;
        pending       <= pending_words.size();
        words_checked <= n_words;
        parity_words  <= n_parity;
        bad_headers   <= n_header;
    end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the ASK packet word assembler. Drives decoded line bits
// as preamble runs, packets with random payload, aborts and noise under a
// series of preamble windows, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apwa_pkg::*;
    import apwa_tb_pkg::*;

    localparam int N_PHASES = 8;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_PREAMBLE_MIN;
    logic [CFG_W-1:0]     cfg_wdata    = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind       = KIND_UNCOUNTED;
    logic                 s_bit_value  = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [WORD_W-1:0]    m_word;
    logic [INDEX_W-1:0]   m_word_index;
    logic [STATUS_W-1:0]  m_status;
    logic                 m_last;

    int mismatches;
    int pending;
    int words_checked;
    int parity_words;
    int bad_headers;

    int win_lo          = PREAMBLE_MIN_RST;
    int win_hi          = PREAMBLE_MAX_RST;
    int burst_left      = 0;
    int abort_countdown = -1;
    int items_sent      = 0;
    int phase_end;
    int settle;
    int phase_lo [N_PHASES]    = '{11, 0, 255, 30, 1, 200, 0, 11};
    int phase_hi [N_PHASES]    = '{25, 255, 255, 10, 3, 255, 5, 25};
    int phase_items [N_PHASES] = '{270, 400, 250, 130, 170, 200, 110, 60};

    logic [9:0] stall_tick = '0;

    ask_packet_word_assembler u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_bit_value  (s_bit_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word       (m_word),
        .m_word_index (m_word_index),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    apwa_word_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_bit_value   (s_bit_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .m_word_index  (m_word_index),
        .m_status      (m_status),
        .m_last        (m_last),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked),
        .parity_words  (parity_words),
        .bad_headers   (bad_headers)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_ready <= (stall_tick[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic bit_v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_bit_value <= bit_v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic set_window(input int lo, input int hi);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PREAMBLE_MIN;
        cfg_wdata <= CFG_W'(lo);
        @(posedge aclk);
        cfg_index <= CFG_PREAMBLE_MAX;
        cfg_wdata <= CFG_W'(hi);
        @(posedge aclk);
        cfg_we <= 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    // set odd parity over bits 9..1, now and then break it
    function automatic logic [WORD_W-1:0] seal_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] s;
        int                flip;
        s    = w;
        s[1] = ~^s[9:2];
        if ($urandom_range(0, 19) == 0) begin
            flip    = $urandom_range(1, 9);
            s[flip] = ~s[flip];
        end
        return s;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input bit random_kinds);
        logic [KIND_W-1:0] k;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (abort_countdown == 0)
                send_item(KIND_ABORT, 1'($urandom_range(0, 1)));
            abort_countdown--;
            if (random_kinds)
                k = KIND_W'($urandom_range(0, 2));
            else if (b == 0)
                k = KIND_UNCOUNTED;
            else
                k = KIND_W'(b % 3);
            send_item(k, w[b]);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 24);
        repeat (n) send_item(KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_packet(input bit keep_counts);
        int               n_pre;
        int               n_data;
        int               r;
        logic [8:0]       hdr;
        logic [WORD_W-1:0] w;
        if (!keep_counts && $urandom_range(0, 9) != 0)
            send_item(KIND_ABORT, 1'($urandom_range(0, 1)));
        r = $urandom_range(0, 9);
        if (win_lo > win_hi) begin
            n_pre = $urandom_range(0, 40);
        end else if (r == 0 && win_lo > 0) begin
            n_pre = win_lo - 1;
        end else if (r == 1 && win_hi < 255) begin
            n_pre = win_hi + 1;
        end else begin
            n_pre = win_lo + $urandom_range(0, (win_hi - win_lo < 12) ? win_hi - win_lo : 12);
            if (win_hi == 255)
                n_pre += $urandom_range(0, 4);
        end
        repeat (n_pre) send_item(KIND_PREAMBLE, 1'b1);
        case ($urandom_range(0, 15))
            0, 1:     hdr = HDR_SIGNAL;
            2, 3:     hdr = HDR_CTRL_ERR;
            4, 5:     hdr = HDR_RX_POWER;
            6, 7:     hdr = HDR_CONFIG;
            8, 9, 10: hdr = HDR_IDENT;
            11, 12:   hdr = HDR_FILL;
            default:  hdr = {1'b0, 8'($urandom)};
        endcase
        n_data = words_in_packet(hdr);
        n_data = (n_data == 0) ? $urandom_range(0, 2) : n_data - 1;
        abort_countdown = ($urandom_range(0, 11) == 0) ?
                          $urandom_range(0, WORD_W * (n_data + 1) - 1) : -1;
        send_word(seal_word({hdr, 1'b0, 1'($urandom_range(0, 1))}), 1'b1);
        repeat (n_data) send_word(seal_word(WORD_W'($urandom)), 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // zero-length window: a start zero right after idle opens a packet
        set_window(0, 0);
        send_item(KIND_ABORT, 1'b1);
        send_word({HDR_FILL, ^HDR_FILL[7:0], 1'b1}, 1'b0);
        send_word({9'h0AA, ~^8'hAA, 1'b0}, 1'b0);
        send_item(KIND_ABORT, 1'b0);

        for (int p = 0; p < N_PHASES; p++) begin
            send_item(KIND_ABORT, 1'($urandom_range(0, 1)));
            set_window(phase_lo[p], phase_hi[p]);
            phase_end = items_sent + phase_items[p];
            if (win_lo == 0 && win_hi == 255) begin
                repeat (260) send_item(KIND_OTHER, 1'b1);
                send_packet(1'b1);
            end
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0)
                    send_noise();
                send_packet(1'b0);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        settle = 0;
        while (pending != 0 && settle < 5000) begin
            @(posedge aclk);
            settle++;
        end
        repeat (8) @(posedge aclk);
        if (pending != 0)
            $display("%0d expected words never arrived", pending);
        $display("Sent %0d bit requests across %0d preamble windows.", items_sent,
                 N_PHASES + 1);
        $display("Checked %0d words: %0d with parity errors, %0d with unknown headers.",
                 words_checked, parity_words, bad_headers);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
